// ===== rtl/core/bounded_deque_with_key_removal_macros.svh =====
// Assertion macros shared by the deque block.
`ifndef BOUNDED_DEQUE_WITH_KEY_REMOVAL_MACROS_SVH
`define BOUNDED_DEQUE_WITH_KEY_REMOVAL_MACROS_SVH

// Checks an expression at every clock edge outside reset.
`define BDQ_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define BDQ_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies another in the next cycle.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bdq_pkg.sv =====
// Shared constants, types and helpers of the deque block.
`default_nettype none

package bdq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;
    localparam int COUNT_W  = 5;

    // Stream widths: the input carries the value, the output carries count, front, back.
    localparam int IN_TDATA_W  = ((DATA_W + 7) / 8) * 8;
    localparam int OUT_BITS    = COUNT_W + 2 * DATA_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [OP_W-1:0]   op_code_t;
    typedef logic [ST_W-1:0]   status_t;

    localparam op_code_t OP_PUSH_FRONT = 3'd0;
    localparam op_code_t OP_PUSH_BACK  = 3'd1;
    localparam op_code_t OP_POP_FRONT  = 3'd2;
    localparam op_code_t OP_POP_BACK   = 3'd3;
    localparam op_code_t OP_REMOVE     = 3'd4;

    localparam status_t ST_DONE     = 2'd0;
    localparam status_t ST_EMPTY    = 2'd1;
    localparam status_t ST_NOTFOUND = 2'd2;
    localparam status_t ST_FULL     = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture the incoming request
        logic exec;       // carry out push or pop, prepare a removal
        logic scan_rd;    // read the entry at the scan position
        logic scan_miss;  // step the scan position
        logic not_found;  // record a failed search
        logic shift_rd;   // read the entry after the shift position
        logic shift_wr;   // move that entry one place toward the front
        logic shrink;     // drop one element after a removal
        logic fetch;      // read the front and back entries
        logic load_out;   // load the result register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_remove;
        logic scan_end;
        logic match;
        logic shift_end;
        logic out_free;
        cnt_t count;
    } dp_sts_t;

    // Physical slot of a logical position; base and pos add to less than twice the depth.
    function automatic idx_t slot_of(input idx_t base, input cnt_t pos);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(pos);
        if (sum >= (CNT_W + 1)'(CAPACITY)) begin
            sum = sum - (CNT_W + 1)'(CAPACITY);
        end
        return IDX_W'(sum);
    endfunction

    // Slot just before the given one, wrapping at the bottom.
    function automatic idx_t slot_dec(input idx_t base);
        idx_t res;
        if (base == '0) begin
            res = IDX_W'(CAPACITY - 1);
        end else begin
            res = base - 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bdq_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
`default_nettype none

module bdq_ctrl
    import bdq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_FETCH,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.is_remove ? S_SCAN_RD : S_FETCH;
            end
            S_SCAN_RD:
            begin
                if (sts.scan_end)
                begin
                    cmd.not_found = 1'b1;
                    state_next    = S_FETCH;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (sts.match)
                begin
                    state_next = S_SHIFT_CHK;
                end
                else
                begin
                    cmd.scan_miss = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_SHIFT_CHK:
            begin
                if (sts.shift_end)
                begin
                    cmd.shrink = 1'b1;
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_CHK;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bdq_dp.sv =====
// Datapath: element memory, front index, count, scan position and result register.
`default_nettype none

module bdq_dp
    import bdq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dp_cmd_t  cmd,
    output dp_sts_t       sts,
    input  wire op_code_t req_operation,
    input  wire data_t    req_value,
    input  wire logic     out_ready,
    output logic          out_valid,
    output status_t       out_status,
    output cnt_t          out_count,
    output data_t         out_front,
    output data_t         out_back
);

    data_t mem [CAPACITY];

    op_code_t op_reg;
    data_t    value_reg;
    idx_t     front_reg;
    idx_t     front_next;
    cnt_t     count_reg;
    cnt_t     count_next;
    cnt_t     pos_reg;
    cnt_t     pos_next;
    status_t  status_reg;
    status_t  status_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    data_t    rdata_a_reg;
    data_t    rdata_b_reg;
    status_t  out_status_reg;
    cnt_t     out_count_reg;
    data_t    out_front_reg;
    data_t    out_back_reg;

    logic  full;
    logic  empty;
    cnt_t  pos_inc;
    cnt_t  last_pos;
    logic  wr_en;
    idx_t  wr_addr;
    data_t wr_data;
    logic  rd_a_en;
    idx_t  rd_a_addr;
    logic  rd_b_en;
    idx_t  rd_b_addr;

    assign full     = (count_reg >= CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign pos_inc  = pos_reg + 1'b1;
    assign last_pos = empty ? '0 : count_reg - 1'b1;

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = slot_of(front_reg, pos_reg);
        wr_data     = rdata_a_reg;

        if (cmd.exec)
        begin
            status_next = ST_DONE;
            pos_next    = '0;
            unique case (op_reg)
                OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        front_next = slot_dec(front_reg);
                        count_next = count_reg + 1'b1;
                        wr_en      = 1'b1;
                        wr_addr    = slot_dec(front_reg);
                        wr_data    = value_reg;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        wr_en      = 1'b1;
                        wr_addr    = slot_of(front_reg, count_reg);
                        wr_data    = value_reg;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        front_next = slot_of(front_reg, CNT_W'(1));
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    // Removal starts its scan; unused codes leave everything as it is.
                end
            endcase
        end

        if (cmd.not_found)
        begin
            status_next = ST_NOTFOUND;
        end
        if (cmd.scan_miss)
        begin
            pos_next = pos_inc;
        end
        if (cmd.shift_wr)
        begin
            wr_en    = 1'b1;
            wr_addr  = slot_of(front_reg, pos_reg);
            wr_data  = rdata_a_reg;
            pos_next = pos_inc;
        end
        if (cmd.shrink)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Read port A serves the scan, the shift and the front; port B the back.
    always_comb
    begin
        rd_a_en   = cmd.scan_rd | cmd.shift_rd | cmd.fetch;
        rd_b_en   = cmd.fetch;
        rd_b_addr = slot_of(front_reg, last_pos);
        priority if (cmd.shift_rd)
        begin
            rd_a_addr = slot_of(front_reg, pos_inc);
        end
        else if (cmd.fetch)
        begin
            rd_a_addr = front_reg;
        end
        else
        begin
            rd_a_addr = slot_of(front_reg, pos_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rdata_a_reg <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rdata_b_reg <= mem[rd_b_addr];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            status_reg    <= ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= req_operation;
            value_reg <= req_value;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= count_reg;
            out_front_reg  <= empty ? '0 : rdata_a_reg;
            out_back_reg   <= empty ? '0 : rdata_b_reg;
        end
    end

    assign sts.is_remove = (op_reg == OP_REMOVE);
    assign sts.scan_end  = (pos_reg >= count_reg);
    assign sts.match     = (rdata_a_reg == value_reg);
    assign sts.shift_end = (pos_inc >= count_reg);
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.count     = count_reg;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;
    assign out_front  = out_front_reg;
    assign out_back   = out_back_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bounded_deque_with_key_removal.sv =====
// Top level of the bounded deque with removal by key.
`default_nettype none

`include "bounded_deque_with_key_removal_macros.svh"

// This block keeps an ordered sequence of up to CAPACITY (16) signed 32-bit
// values in a circular memory. Each request on the slave stream pushes at the
// front or back, pops from the front or back, or removes the first element,
// counted from the front, that equals the request's value. Every request
// gives exactly one result on the master stream with a status (done, was
// empty, key not found, was full), the element count after the request, and
// the front and back values, which read as zero when the store is empty.
// Requests are handled one at a time by a controller that steps a datapath
// with a single-write, dual-read memory. A removal walks the memory through
// one read port, examining elements from the front and then moving each
// element behind the match one place toward the front. The result sits in
// an output register, so the next request can be accepted while the
// previous result still waits to be taken. There is no clearing pass after
// reset; the block is ready at once.

module bounded_deque_with_key_removal
    import bdq_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] value
    input  wire logic [OP_W-1:0]        s_tuser,   // [2:0] operation
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // [4:0] count, [36:5] front_value,
                                                   // [68:37] back_value, rest zero
    output logic [ST_W-1:0]             m_tuser    // [1:0] status
);

    dp_cmd_t cmd;
    dp_sts_t sts;
    status_t out_status;
    cnt_t    out_count;
    data_t   out_front;
    data_t   out_back;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bdq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_operation (s_tuser),
        .req_value     (s_tdata[DATA_W-1:0]),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_status    (out_status),
        .out_count     (out_count),
        .out_front     (out_front),
        .out_back      (out_back)
    );

    // The count field is fixed at five bits on the stream.
    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_back, out_front, COUNT_W'(out_count)};
    assign m_tuser = out_status;

    // A request is taken only when the controller is idle, so it is busy right after.
    `BDQ_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready, "ready after request")
    // The result register is loaded only when its previous content is gone or leaving.
    `BDQ_ASSERT_IMPLY(a_load_when_free, cmd.load_out, !m_tvalid || m_tready, "result overwritten")
    // The element count never goes past the capacity.
    `BDQ_ASSERT_ALWAYS(a_count_bound, sts.count <= CNT_W'(CAPACITY), "count beyond capacity")
    // Memory moves and the final fetch never overlap.
    `BDQ_ASSERT_IMPLY(a_fetch_alone, cmd.fetch, !cmd.shift_wr && !cmd.scan_rd, "fetch overlap")

endmodule

`default_nettype wire

// ===== tb/bounded_deque_with_key_removal_test.sv =====
// Self-checking testbench for the bounded deque with removal by key.
`timescale 1ns / 100ps

module bounded_deque_with_key_removal_test
    import bdq_pkg::*;
;

    // One request as the stimulus plan sees it: the operation and value, the idle
    // cycles the sender spends before offering it, and whether the sender must
    // first wait until every outstanding result has been taken.
    typedef struct packed {
        op_code_t   op;
        data_t      value;
        logic [3:0] lead_gap;
        logic       drain_first;
    } request_t;

    // One result as it appears on the master stream, unpacked into its fields.
    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   count;
        data_t                front;
        data_t                back;
        logic [OUT_PAD_W-1:0] pad;
    } reply_t;

    // The deque contents as the checker tracks them: a circular store, the
    // slot of the first element and the number of elements held.
    typedef struct packed {
        logic [CAPACITY-1:0][DATA_W-1:0] store;
        idx_t                            head;
        cnt_t                            cnt;
    } deque_t;

    // Traffic mixes that steer the random part toward full, empty, or deep
    // searches, so that every status turns up many times.
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN,
        MIX_SEARCH
    } traffic_mix_t;

    localparam int RANDOM_REQUESTS = 1900;
    localparam int SETTLE_CYCLES   = 60;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [31:0] value
    logic [OP_W-1:0]        s_tuser = '0;   // [2:0] operation
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // [4:0] count, [36:5] front_value,
                                            // [68:37] back_value, rest zero
    logic [ST_W-1:0]        m_tuser;        // [1:0] status

    request_t pending[$];       // requests still to be offered
    reply_t   results_due[$];   // predicted results, oldest first
    deque_t   plan_dq;          // contents as the stimulus plan expects them
    deque_t   tracked_dq;       // contents as of the last accepted request
    logic     burst_stretch;    // sender offers requests back to back
    logic     drain_next;       // next planned request waits for a drained pipe
    logic     sink_burst;       // receiver takes results without stalling
    int unsigned idle_count;
    int unsigned stall_left;
    int       mismatches;
    int       pushes_sent;
    int       pops_sent;
    int       removals_sent;
    int       unused_sent;
    int       status_seen[4];
    int       deepest;

    bounded_deque_with_key_removal i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Physical slot of a logical position counted from the head.
    function automatic idx_t wrap(input int pos);
        return idx_t'(pos % CAPACITY);
    endfunction

    // Applies one request to a deque and returns the result it should produce.
    // A push into a full deque, a pop from an empty one and a removal that
    // finds no match leave the contents alone; unused codes also do nothing.
    function automatic reply_t apply_request(inout deque_t dq, input op_code_t op,
                                             input data_t val);
        reply_t r;
        int     hit;
        int     i;
        r        = '0;
        r.status = ST_DONE;
        case (op)
            OP_PUSH_FRONT:
            begin
                if (dq.cnt >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    dq.head           = wrap(int'(dq.head) + CAPACITY - 1);
                    dq.store[dq.head] = val;
                    dq.cnt            = dq.cnt + 1'b1;
                end
            end
            OP_PUSH_BACK:
            begin
                if (dq.cnt >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    dq.store[wrap(int'(dq.head) + int'(dq.cnt))] = val;
                    dq.cnt = dq.cnt + 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (dq.cnt == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    dq.head = wrap(int'(dq.head) + 1);
                    dq.cnt  = dq.cnt - 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (dq.cnt == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    dq.cnt = dq.cnt - 1'b1;
                end
            end
            OP_REMOVE:
            begin
                // The first match counted from the front goes; everything
                // behind it closes up by one place.
                hit = -1;
                for (i = 0; i < int'(dq.cnt); i++)
                begin
                    if (hit < 0 && dq.store[wrap(int'(dq.head) + i)] == val)
                    begin
                        hit = i;
                    end
                end
                if (hit < 0)
                begin
                    r.status = ST_NOTFOUND;
                end
                else
                begin
                    for (i = hit; i + 1 < int'(dq.cnt); i++)
                    begin
                        dq.store[wrap(int'(dq.head) + i)] =
                            dq.store[wrap(int'(dq.head) + i + 1)];
                    end
                    dq.cnt = dq.cnt - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.count = COUNT_W'(dq.cnt);
        if (dq.cnt != 0)
        begin
            r.front = dq.store[dq.head];
            r.back  = dq.store[wrap(int'(dq.head) + int'(dq.cnt) - 1)];
        end
        return r;
    endfunction

    // Queues one request for the sender and keeps the planned contents current,
    // so that later removal keys can be taken from what the deque will hold.
    task automatic plan_request(input op_code_t op, input data_t val);
        request_t req;
        reply_t   unused_reply;
        req.op          = op;
        req.value       = val;
        req.lead_gap    = burst_stretch ? 4'd0 : 4'($urandom_range(0, 12));
        req.drain_first = drain_next;
        drain_next      = 1'b0;
        pending.push_back(req);
        unused_reply = apply_request(plan_dq, op, val);
    endtask

    // Values lean on a small pool around zero so that duplicates and matching
    // keys are common, with the field extremes and wide random values mixed in.
    function automatic data_t pick_value();
        data_t v;
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
        begin
            v = $urandom();
        end
        else if (roll < 7)
        begin
            v = data_t'($urandom_range(0, 6)) - data_t'(3);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'hFFFF_FFFF;
                default: v = 32'h0000_0000;
            endcase
        end
        return v;
    endfunction

    // Removal key: most often an element that is present, picked at a random
    // position, otherwise any value, which may or may not be held.
    function automatic data_t pick_key();
        data_t k;
        int    pos;
        if (plan_dq.cnt != 0 && $urandom_range(0, 9) < 7)
        begin
            pos = $urandom_range(0, int'(plan_dq.cnt) - 1);
            k   = plan_dq.store[wrap(int'(plan_dq.head) + pos)];
        end
        else
        begin
            k = pick_value();
        end
        return k;
    endfunction

    // Stimulus plan: a directed opening, then random traffic in stretches of
    // varying mix and pacing.
    initial
    begin
        traffic_mix_t mix;
        int           push_w;
        int           pop_w;
        int           roll;
        int           n;
        op_code_t     op;

        plan_dq       = '0;
        burst_stretch = 1'b0;
        drain_next    = 1'b0;

        // Requests on an empty deque: both pops report empty, a removal finds
        // nothing, and the unused codes change nothing.
        plan_request(OP_POP_FRONT, 32'h0000_0000);
        plan_request(OP_POP_BACK, 32'hFFFF_FFFF);
        plan_request(OP_REMOVE, 32'h0000_0000);
        plan_request(op_code_t'(5), 32'h8000_0000);
        plan_request(op_code_t'(6), 32'h7FFF_FFFF);
        plan_request(op_code_t'(7), 32'h5A5A_A5A5);

        // Fill to capacity from both ends, so the head wraps below slot zero,
        // with the value extremes and a duplicated value among the entries.
        plan_request(OP_PUSH_FRONT, 32'h8000_0000);
        plan_request(OP_PUSH_BACK, 32'h7FFF_FFFF);
        plan_request(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        plan_request(OP_PUSH_BACK, 32'h0000_0000);
        plan_request(OP_PUSH_BACK, 32'd7);
        for (n = 0; n < 10; n++)
        begin
            plan_request((n % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                         data_t'(n * 32'h1357_9BDF));
        end
        plan_request(OP_PUSH_BACK, 32'd7);

        // Both pushes bounce off a full deque.
        plan_request(OP_PUSH_BACK, 32'h1234_5678);
        plan_request(OP_PUSH_FRONT, 32'h1234_5678);

        // The first of two equal entries goes and the tail closes up, then a
        // key that is not held, then one pop from each end.
        plan_request(OP_REMOVE, 32'd7);
        plan_request(OP_REMOVE, 32'h0BAD_F00D);
        plan_request(OP_POP_FRONT, 32'h0000_0000);
        plan_request(OP_POP_BACK, 32'h0000_0000);

        // Random traffic. The first random request waits for a drained pipe.
        drain_next = 1'b1;
        mix        = MIX_EVEN;
        push_w     = 40;
        pop_w      = 30;
        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 40 == 0)
            begin
                mix           = traffic_mix_t'($urandom_range(0, 3));
                burst_stretch = ($urandom_range(0, 3) == 0);
                case (mix)
                    MIX_FILL:
                    begin
                        push_w = 70;
                        pop_w  = 15;
                    end
                    MIX_DRAIN:
                    begin
                        push_w = 15;
                        pop_w  = 70;
                    end
                    MIX_EVEN:
                    begin
                        push_w = 40;
                        pop_w  = 30;
                    end
                    default:
                    begin
                        push_w = 45;
                        pop_w  = 10;
                    end
                endcase
            end
            if ($urandom_range(0, 99) == 0)
            begin
                drain_next = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                op = op_code_t'($urandom_range(5, 7));
            end
            else if (roll < 2 + push_w)
            begin
                op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            end
            else if (roll < 2 + push_w + pop_w)
            begin
                op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            end
            else
            begin
                op = OP_REMOVE;
            end
            plan_request(op, (op == OP_REMOVE) ? pick_key() : pick_value());
        end
    end

    // Request driver. A request stays offered until it is taken; the next one
    // follows after its own lead gap, and a request marked to drain waits
    // until every predicted result has been consumed. The prediction is made
    // at the edge where the request is accepted.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        logic     offering;
        request_t nxt;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            idle_count = 0;
            tracked_dq = '0;
        end
        else
        begin
            offering = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                results_due.push_back(apply_request(tracked_dq, op_code_t'(s_tuser),
                                                    s_tdata[DATA_W-1:0]));
                case (op_code_t'(s_tuser))
                    OP_PUSH_FRONT, OP_PUSH_BACK: pushes_sent++;
                    OP_POP_FRONT, OP_POP_BACK:   pops_sent++;
                    OP_REMOVE:                   removals_sent++;
                    default:                     unused_sent++;
                endcase
                if (int'(tracked_dq.cnt) > deepest)
                begin
                    deepest = int'(tracked_dq.cnt);
                end
                offering = 1'b0;
            end
            if (!offering && pending.size() != 0)
            begin
                if (idle_count < int'(pending[0].lead_gap))
                begin
                    idle_count++;
                end
                else if (!pending[0].drain_first || results_due.size() == 0)
                begin
                    nxt        = pending.pop_front();
                    s_tdata    <= nxt.value;
                    s_tuser    <= nxt.op;
                    offering   = 1'b1;
                    idle_count = 0;
                end
            end
            s_tvalid <= offering;
        end
    end

    // Reports one bad result; only the first few are printed in full.
    task automatic log_mismatch(input string what, input reply_t want, input reply_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s", $realtime, what);
            $display("    expected status %0d count %0d front %h back %h pad %h",
                     want.status, want.count, want.front, want.back, want.pad);
            $display("    actual   status %0d count %0d front %h back %h pad %h",
                     got.status, got.count, got.front, got.back, got.pad);
        end
    endtask

    // Result monitor. Each accepted result is unpacked and compared with the
    // oldest prediction. After each result the receiver may stall for a
    // random number of cycles; stretches without stalls come and go.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        logic   taking;
        reply_t got;
        reply_t want;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left = 0;
            sink_burst = 1'b0;
        end
        else
        begin
            taking = m_tready;
            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                got.count  = m_tdata[COUNT_W-1:0];
                got.front  = m_tdata[COUNT_W +: DATA_W];
                got.back   = m_tdata[COUNT_W + DATA_W +: DATA_W];
                got.pad    = m_tdata[OUT_TDATA_W-1:OUT_BITS];
                status_seen[got.status]++;
                if (results_due.size() == 0)
                begin
                    log_mismatch("result with no request outstanding", '0, got);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got != want)
                    begin
                        log_mismatch("result differs from prediction", want, got);
                    end
                end
                if ($urandom_range(0, 59) == 0)
                begin
                    sink_burst = ~sink_burst;
                end
                stall_left = sink_burst ? 0 : $urandom_range(0, 12);
                taking     = (stall_left == 0);
            end
            else if (!m_tready)
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                end
                taking = (stall_left == 0);
            end
            m_tready <= taking;
        end
    end

    // End of run: wait until every request has been offered, taken and
    // answered, let the block settle, then give the verdict.
    initial
    begin
        mismatches    = 0;
        pushes_sent   = 0;
        pops_sent     = 0;
        removals_sent = 0;
        unused_sent   = 0;
        deepest       = 0;
        status_seen   = '{default: 0};
        @(posedge rst_n);
        while (pending.size() != 0 || s_tvalid || results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Requests: %0d pushes, %0d pops, %0d removals, %0d unused codes; deepest %0d.",
                 pushes_sent, pops_sent, removals_sent, unused_sent, deepest);
        $display("Statuses: %0d done, %0d empty, %0d not found, %0d full; %0d mismatches.",
                 status_seen[ST_DONE], status_seen[ST_EMPTY], status_seen[ST_NOTFOUND],
                 status_seen[ST_FULL], mismatches);
        if (mismatches == 0 && results_due.size() == 0)
        begin
            $display("[bounded_deque_with_key_removal] OK");
        end
        else
        begin
            $display("[bounded_deque_with_key_removal] ERROR");
        end
        $finish;
    end

    // Watchdog: a correct run ends well before this timeout even with
    // every removal at full depth and the longest gaps and stalls.
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d requests pending and %0d results outstanding.",
                 pending.size(), results_due.size());
        $display("[bounded_deque_with_key_removal] ERROR");
        $finish;
    end

endmodule
